/* hdl/pmsp_pkg.sv */
// ----------------------------------------------------------------------------
// pmsp_pkg
// Types, sizes and codes shared by the periodic placer modules.
// ----------------------------------------------------------------------------
package pmsp_pkg;

	localparam int GRID_SIZE  = 1024;
	localparam int CAPACITY   = 2048;
	localparam int COORD_W    = 10;
	localparam int CNT_W      = 12;
	localparam int ADDR_W     = 11;
	localparam int IMG_W      = 12;
	localparam int SQ_W       = 22;
	localparam int SUM_W      = 23;
	localparam int SEP_W      = 22;
	localparam int MARGIN_W   = 9;
	localparam int ZONE_W     = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 22;
	localparam int STEP_W     = 3;
	localparam int ENTRY_W    = 2 * COORD_W;

	localparam logic [CFG_IDX_W-1:0] REG_SEP_SQ_LIMIT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_MARGIN  = CFG_IDX_W'(1);

	localparam logic [SEP_W-1:0]    SEP_SQ_LIMIT_RST = SEP_W'(400);
	localparam logic [MARGIN_W-1:0] EDGE_MARGIN_RST  = MARGIN_W'(13);

	localparam logic [ZONE_W-1:0] ZONE_INTERIOR = ZONE_W'(0);
	localparam logic [ZONE_W-1:0] ZONE_LX       = ZONE_W'(1);
	localparam logic [ZONE_W-1:0] ZONE_HX       = ZONE_W'(2);
	localparam logic [ZONE_W-1:0] ZONE_LY       = ZONE_W'(3);
	localparam logic [ZONE_W-1:0] ZONE_HY       = ZONE_W'(4);
	localparam logic [ZONE_W-1:0] ZONE_LX_LY    = ZONE_W'(5);
	localparam logic [ZONE_W-1:0] ZONE_LX_HY    = ZONE_W'(6);
	localparam logic [ZONE_W-1:0] ZONE_HX_LY    = ZONE_W'(7);
	localparam logic [ZONE_W-1:0] ZONE_HX_HY    = ZONE_W'(8);

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_WAIT   = STEP_W'(0);
	localparam step_t STEP_PREP   = STEP_W'(1);
	localparam step_t STEP_SCAN   = STEP_W'(2);
	localparam step_t STEP_DRAIN  = STEP_W'(3);
	localparam step_t STEP_DECIDE = STEP_W'(4);

	typedef enum logic [2:0] {
		COND_NO_ACCEPT,
		COND_CNT_ZERO,
		COND_NOT_LAST,
		COND_PIPE_BUSY,
		COND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		logic  in_ready;
		logic  prep;
		logic  scan;
		logic  decide;
		cond_t cond;
		step_t jmp;
		step_t nxt;
	} uw_t;

	typedef struct packed {
		logic no_accept;
		logic cnt_zero;
		logic not_last;
		logic pipe_busy;
		logic out_busy;
	} cond_flags_t;

	typedef struct packed {
		logic [COORD_W-1:0] cand_x;
		logic [COORD_W-1:0] cand_y;
	} cand_t;

	typedef struct packed {
		logic              accepted;
		logic [CNT_W-1:0]  stored_count;
		logic              table_full;
		logic [ZONE_W-1:0] border_zone;
	} res_t;

endpackage

/* hdl/pmsp_ram.sv */
// ----------------------------------------------------------------------------
// pmsp_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module pmsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hdl/pmsp_useq.sv */
// ----------------------------------------------------------------------------
// pmsp_useq
// Microcode sequencer: control store, step counter and conditional jumps.
// ----------------------------------------------------------------------------
module pmsp_useq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pmsp_pkg::cond_flags_t flags,
	output pmsp_pkg::uw_t         uw
);

	function automatic pmsp_pkg::uw_t rom(input pmsp_pkg::step_t s);
		pmsp_pkg::uw_t w;
		w = '{in_ready: 1'b0, prep: 1'b0, scan: 1'b0, decide: 1'b0,
			cond: pmsp_pkg::COND_NO_ACCEPT, jmp: pmsp_pkg::STEP_WAIT,
			nxt: pmsp_pkg::STEP_WAIT};
		unique case (s)
			pmsp_pkg::STEP_WAIT: begin
				w.in_ready = 1'b1;
				w.cond     = pmsp_pkg::COND_NO_ACCEPT;
				w.jmp      = pmsp_pkg::STEP_WAIT;
				w.nxt      = pmsp_pkg::STEP_PREP;
			end
			pmsp_pkg::STEP_PREP: begin
				w.prep = 1'b1;
				w.cond = pmsp_pkg::COND_CNT_ZERO;
				w.jmp  = pmsp_pkg::STEP_DECIDE;
				w.nxt  = pmsp_pkg::STEP_SCAN;
			end
			pmsp_pkg::STEP_SCAN: begin
				w.scan = 1'b1;
				w.cond = pmsp_pkg::COND_NOT_LAST;
				w.jmp  = pmsp_pkg::STEP_SCAN;
				w.nxt  = pmsp_pkg::STEP_DRAIN;
			end
			pmsp_pkg::STEP_DRAIN: begin
				w.cond = pmsp_pkg::COND_PIPE_BUSY;
				w.jmp  = pmsp_pkg::STEP_DRAIN;
				w.nxt  = pmsp_pkg::STEP_DECIDE;
			end
			pmsp_pkg::STEP_DECIDE: begin
				w.decide = 1'b1;
				w.cond   = pmsp_pkg::COND_OUT_BUSY;
				w.jmp    = pmsp_pkg::STEP_DECIDE;
				w.nxt    = pmsp_pkg::STEP_WAIT;
			end
			default: begin
				w.cond = pmsp_pkg::COND_NO_ACCEPT;
				w.jmp  = pmsp_pkg::STEP_WAIT;
				w.nxt  = pmsp_pkg::STEP_WAIT;
			end
		endcase
		return w;
	endfunction

	pmsp_pkg::step_t step_q;
	logic            taken;

	assign uw = rom(step_q);

	always_comb begin
		unique case (uw.cond)
			pmsp_pkg::COND_NO_ACCEPT: taken = flags.no_accept;
			pmsp_pkg::COND_CNT_ZERO:  taken = flags.cnt_zero;
			pmsp_pkg::COND_NOT_LAST:  taken = flags.not_last;
			pmsp_pkg::COND_PIPE_BUSY: taken = flags.pipe_busy;
			pmsp_pkg::COND_OUT_BUSY:  taken = flags.out_busy;
			default:                  taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= pmsp_pkg::STEP_WAIT;
		end else begin
			step_q <= taken ? uw.jmp : uw.nxt;
		end
	end

endmodule

/* hdl/pmsp_dist.sv */
// ----------------------------------------------------------------------------
// pmsp_dist
// Two-stage squared-distance check of four candidate images against one entry.
// ----------------------------------------------------------------------------
module pmsp_dist (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  rd_v_s1,
	input  logic signed [pmsp_pkg::IMG_W-1:0]     xa,
	input  logic signed [pmsp_pkg::IMG_W-1:0]     xb,
	input  logic signed [pmsp_pkg::IMG_W-1:0]     ya,
	input  logic signed [pmsp_pkg::IMG_W-1:0]     yb,
	input  logic [pmsp_pkg::ENTRY_W-1:0]          entry_s1,
	input  logic [pmsp_pkg::SEP_W-1:0]            sep_sq_limit,
	output logic                                  hit_v,
	output logic                                  hit
);

	localparam int IW = pmsp_pkg::IMG_W;
	localparam int CW = pmsp_pkg::COORD_W;
	localparam int QW = pmsp_pkg::SQ_W;
	localparam int UW = pmsp_pkg::SUM_W;

	logic signed [IW-1:0]   sx, sy;
	logic signed [IW-1:0]   dxa, dxb, dya, dyb;
	logic signed [2*IW-1:0] pxa, pxb, pya, pyb;
	logic [QW-1:0]          qxa_s2, qxb_s2, qya_s2, qyb_s2;
	logic                   v_s2;
	logic [UW-1:0]          lim;
	logic [UW-1:0]          s_aa, s_ba, s_ab, s_bb;

	assign sx  = $signed({{(IW-CW){1'b0}}, entry_s1[2*CW-1:CW]});
	assign sy  = $signed({{(IW-CW){1'b0}}, entry_s1[CW-1:0]});
	assign dxa = xa - sx;
	assign dxb = xb - sx;
	assign dya = ya - sy;
	assign dyb = yb - sy;
	assign pxa = dxa * dxa;
	assign pxb = dxb * dxb;
	assign pya = dya * dya;
	assign pyb = dyb * dyb;

	always_ff @(posedge clk) begin
		qxa_s2 <= pxa[QW-1:0];
		qxb_s2 <= pxb[QW-1:0];
		qya_s2 <= pya[QW-1:0];
		qyb_s2 <= pyb[QW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= rd_v_s1;
		end
	end

	assign lim  = {1'b0, sep_sq_limit};
	assign s_aa = {1'b0, qxa_s2} + {1'b0, qya_s2};
	assign s_ba = {1'b0, qxb_s2} + {1'b0, qya_s2};
	assign s_ab = {1'b0, qxa_s2} + {1'b0, qyb_s2};
	assign s_bb = {1'b0, qxb_s2} + {1'b0, qyb_s2};

	assign hit_v = v_s2;
	assign hit   = (s_aa < lim) || (s_ba < lim) || (s_ab < lim) || (s_bb < lim);

endmodule

/* hdl/periodic_min_separation_placer_core.sv */
// ----------------------------------------------------------------------------
// periodic_min_separation_placer_core
// Periodic-boundary minimum-separation placer for candidate particle centres.
// ----------------------------------------------------------------------------
// Usage:
//   cand channel (valid/ready) carries one candidate centre per request.
//   res channel (valid/ready) returns one result per request: accepted flag,
//   count of stored centres, table-full flag and border zone.
//   cfg channel writes sep_sq_limit (index 0) or edge_margin (index 1);
//   cfg_ready is always high, other indexes are ignored.
// Timing:
//   With N centres stored, a request walks all N table entries before its
//   result is valid; the walk is skipped when N is 0. The scan reads one
//   table entry per cycle through the single read port of the centre RAM,
//   so the table walk dominates the time a request takes.
//   One request is worked on at a time; the next is taken while the previous
//   result still waits in the output register.
// Reset: registers return to 400 and 13, the table count to zero; the RAM
//   contents are not cleared. A stalled receiver holds the result and the
//   sequencer waits before posting the next one.
// ----------------------------------------------------------------------------
module periodic_min_separation_placer_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cand_valid,
	output logic                                cand_ready,
	input  pmsp_pkg::cand_t                     cand,
	output logic                                res_valid,
	input  logic                                res_ready,
	output pmsp_pkg::res_t                      res,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pmsp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pmsp_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CW = pmsp_pkg::COORD_W;
	localparam int IW = pmsp_pkg::IMG_W;
	localparam int NW = pmsp_pkg::CNT_W;
	localparam int AW = pmsp_pkg::ADDR_W;

	localparam logic signed [IW-1:0] GRID_IMG = IW'(pmsp_pkg::GRID_SIZE);
	localparam logic [CW-1:0]        GRID_TOP = CW'(pmsp_pkg::GRID_SIZE - 1);
	localparam logic [NW-1:0]        CAP_CNT  = NW'(pmsp_pkg::CAPACITY);

	pmsp_pkg::uw_t         uw;
	pmsp_pkg::cond_flags_t flags;

	logic [pmsp_pkg::SEP_W-1:0]    sep_sq_limit_q;
	logic [pmsp_pkg::MARGIN_W-1:0] edge_margin_q;

	pmsp_pkg::cand_t              cand_q;
	logic signed [IW-1:0]         xa_q, xb_q, ya_q, yb_q;
	logic [pmsp_pkg::ZONE_W-1:0]  zone_q;
	logic [AW-1:0]                idx_q;
	logic [NW-1:0]                count_q;
	logic                         conflict_q;
	logic                         rd_v_s1;
	logic                         res_valid_q;
	pmsp_pkg::res_t               res_q;

	logic                         cand_acc;
	logic [CW-1:0]                m_ext, hi;
	logic                         lx, hx, ly, hy;
	logic signed [IW-1:0]         xe, ye, ix, iy;
	logic [pmsp_pkg::ZONE_W-1:0]  zone;
	logic [pmsp_pkg::ENTRY_W-1:0] entry_s1;
	logic                         hit_v, hit;
	logic                         out_busy, decide_fire;
	logic                         no_conf, room, take;

	pmsp_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.uw     (uw)
	);

	pmsp_ram #(
		.WIDTH (pmsp_pkg::ENTRY_W),
		.DEPTH (pmsp_pkg::CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (decide_fire && take),
		.waddr (count_q[AW-1:0]),
		.wdata ({cand_q.cand_x, cand_q.cand_y}),
		.re    (uw.scan),
		.raddr (idx_q),
		.rdata (entry_s1)
	);

	pmsp_dist u_dist (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd_v_s1      (rd_v_s1),
		.xa           (xa_q),
		.xb           (xb_q),
		.ya           (ya_q),
		.yb           (yb_q),
		.entry_s1     (entry_s1),
		.sep_sq_limit (sep_sq_limit_q),
		.hit_v        (hit_v),
		.hit          (hit)
	);

	assign cand_ready  = uw.in_ready;
	assign cand_acc    = cand_valid && cand_ready;
	assign cfg_ready   = 1'b1;
	assign res_valid   = res_valid_q;
	assign res         = res_q;

	assign out_busy    = res_valid_q && !res_ready;
	assign decide_fire = uw.decide && !out_busy;
	assign no_conf     = !conflict_q;
	assign room        = count_q < CAP_CNT;
	assign take        = no_conf && room;

	assign flags.no_accept = !cand_acc;
	assign flags.cnt_zero  = count_q == '0;
	assign flags.not_last  = {1'b0, idx_q} != NW'(count_q - 1'b1);
	assign flags.pipe_busy = rd_v_s1 || hit_v;
	assign flags.out_busy  = out_busy;

	// classify against the edge margin; low edge wins when both apply
	assign m_ext = {1'b0, edge_margin_q};
	assign hi    = GRID_TOP - m_ext;
	assign lx    = cand_q.cand_x < m_ext;
	assign hx    = !lx && (cand_q.cand_x > hi);
	assign ly    = cand_q.cand_y < m_ext;
	assign hy    = !ly && (cand_q.cand_y > hi);
	assign xe    = $signed({{(IW-CW){1'b0}}, cand_q.cand_x});
	assign ye    = $signed({{(IW-CW){1'b0}}, cand_q.cand_y});
	assign ix    = lx ? xe + GRID_IMG : (hx ? xe - GRID_IMG : xe);
	assign iy    = ly ? ye + GRID_IMG : (hy ? ye - GRID_IMG : ye);

	always_comb begin
		if ((lx || hx) && (ly || hy)) begin
			zone = lx ? (ly ? pmsp_pkg::ZONE_LX_LY : pmsp_pkg::ZONE_LX_HY)
			          : (ly ? pmsp_pkg::ZONE_HX_LY : pmsp_pkg::ZONE_HX_HY);
		end else if (lx || hx) begin
			zone = lx ? pmsp_pkg::ZONE_LX : pmsp_pkg::ZONE_HX;
		end else if (ly || hy) begin
			zone = ly ? pmsp_pkg::ZONE_LY : pmsp_pkg::ZONE_HY;
		end else begin
			zone = pmsp_pkg::ZONE_INTERIOR;
		end
	end

	always_ff @(posedge clk) begin
		if (cand_acc) begin
			cand_q <= cand;
		end
		if (uw.prep) begin
			xa_q   <= xe;
			xb_q   <= ix;
			ya_q   <= ye;
			yb_q   <= iy;
			zone_q <= zone;
		end
		if (decide_fire) begin
			res_q.accepted     <= take;
			res_q.stored_count <= take ? NW'(count_q + 1'b1) : count_q;
			res_q.table_full   <= no_conf && !room;
			res_q.border_zone  <= zone_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_sq_limit_q <= pmsp_pkg::SEP_SQ_LIMIT_RST;
			edge_margin_q  <= pmsp_pkg::EDGE_MARGIN_RST;
			idx_q          <= '0;
			count_q        <= '0;
			conflict_q     <= 1'b0;
			rd_v_s1        <= 1'b0;
			res_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					pmsp_pkg::REG_SEP_SQ_LIMIT:
						sep_sq_limit_q <= cfg_data[pmsp_pkg::SEP_W-1:0];
					pmsp_pkg::REG_EDGE_MARGIN:
						edge_margin_q <= cfg_data[pmsp_pkg::MARGIN_W-1:0];
					default: begin
					end
				endcase
			end

			rd_v_s1 <= uw.scan;

			if (uw.prep) begin
				idx_q      <= '0;
				conflict_q <= 1'b0;
			end else begin
				if (uw.scan) begin
					idx_q <= AW'(idx_q + 1'b1);
				end
				if (hit_v && hit) begin
					conflict_q <= 1'b1;
				end
			end

			if (decide_fire && take) begin
				count_q <= NW'(count_q + 1'b1);
			end

			if (decide_fire) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule
